@@ sv/apd_pkg.sv @@
// Types and constants for the addressed packet deframer.
package apd_pkg;

  localparam int BYTE_W  = 8;
  localparam int NIB_W   = 4;
  localparam int CNT_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int OUT_TDATA_W = 24;

  // Register reset values
  localparam logic [BYTE_W-1:0] START_RST     = 8'h41;
  localparam logic [BYTE_W-1:0] OWN_ADDR_RST  = 8'h20;
  localparam logic [BYTE_W-1:0] BCAST_ADDR_RST = 8'h00;

  localparam logic [BYTE_W-1:0] END_BYTE = 8'h0D;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_START_VALUE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_ADDR    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BCAST_ADDR  = 2'd2;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,
    PH_DEST   = 3'd1,
    PH_SOURCE = 3'd2,
    PH_FUNC   = 3'd3,
    PH_DATA   = 3'd4,
    PH_END    = 3'd6
  } phase_t;

  typedef enum logic [3:0] {
    ST_START     = 4'd0,
    ST_RAW       = 4'd1,
    ST_FOR_US    = 4'd2,
    ST_NOT_US    = 4'd3,
    ST_SOURCE    = 4'd4,
    ST_FUNC_LEN  = 4'd5,
    ST_PAYLOAD   = 4'd6,
    ST_SUM_OK    = 4'd7,
    ST_SUM_BAD   = 4'd8,
    ST_DONE      = 4'd9,
    ST_BAD_END   = 4'd10
  } status_t;

  // Result beat, status in the lowest bits
  typedef struct packed {
    logic [CNT_W-1:0]  clear_count;
    logic              buf_clear;
    logic [BYTE_W-1:0] buf_data;
    logic [NIB_W-1:0]  buf_index;
    logic              buf_write;
    status_t           status;
  } result_t;

endpackage

@@ sv/addressed_packet_deframer.sv @@
// Addressed packet deframer: frame receiver with registered result and skid stage.
// A result beat is registered in out_r, or first in the skid register while out_* stalls.
// Throughput: one byte per cycle while in_tready is high; phase, count and sum update per byte.
// A stalled output is absorbed by a one-beat skid register; in_tready drops only when it is full.
// Reset (rst_n low, synchronous): receiver waits for start, counters and sum zero,
// registers return to start 0x41, own address 0x20, broadcast 0x00; no beats pending.
module addressed_packet_deframer (
  input  logic                               clk,
  input  logic                               rst_n,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [apd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [apd_pkg::BYTE_W-1:0]         cfg_wdata,
  // byte stream in
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [apd_pkg::BYTE_W-1:0]         in_tdata,   // [7:0] rx_byte
  // result stream out
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [apd_pkg::OUT_TDATA_W-1:0]    out_tdata   // [3:0] status, [4] buf_write,
                                                         // [8:5] buf_index, [16:9] buf_data,
                                                         // [17] buf_clear, [22:18] clear_count,
                                                         // [23] zero
);
  import apd_pkg::*;

  // configuration registers
  logic [BYTE_W-1:0] start_r, own_r, bcast_r;

  // frame state
  phase_t            phase_r, phase_nxt;
  logic [NIB_W-1:0]  len_r, len_nxt;
  logic [NIB_W-1:0]  cnt_r, cnt_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;

  // output register and skid
  result_t res;
  result_t out_r, out_nxt, skid_r, skid_nxt;
  logic    out_valid_r, out_valid_nxt, skid_valid_r, skid_valid_nxt;

  logic in_fire, out_fire;

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_r};

  // config writes; indexes past the list are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= START_RST;
      own_r   <= OWN_ADDR_RST;
      bcast_r <= BCAST_ADDR_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_START_VALUE) start_r <= cfg_wdata;
      if (cfg_index == CFG_OWN_ADDR)    own_r   <= cfg_wdata;
      if (cfg_index == CFG_BCAST_ADDR)  bcast_r <= cfg_wdata;
    end
  end

  // per-byte step: result and next frame state
  always_comb begin
    res       = '0;
    res.status = ST_START;
    phase_nxt = phase_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    sum_nxt   = sum_r;
    unique case (phase_r)
      PH_START: begin
        if (in_tdata == start_r) begin
          len_nxt   = '0;
          cnt_nxt   = '0;
          sum_nxt   = '0;
          phase_nxt = PH_DEST;
        end else begin
          // stray byte outside a frame goes to buffer slot 0
          res.buf_write = 1'b1;
          res.buf_data  = in_tdata;
          res.status    = ST_RAW;
        end
      end
      PH_DEST: begin
        if (in_tdata == own_r || in_tdata == bcast_r) begin
          phase_nxt  = PH_SOURCE;
          res.status = ST_FOR_US;
        end else begin
          phase_nxt  = PH_START;
          res.status = ST_NOT_US;
        end
      end
      PH_SOURCE: begin
        res.buf_write = 1'b1;
        res.buf_data  = in_tdata;
        res.status    = ST_SOURCE;
        phase_nxt     = PH_FUNC;
      end
      PH_FUNC: begin
        len_nxt       = in_tdata[NIB_W-1:0];
        res.buf_write = 1'b1;
        res.buf_data  = {{(BYTE_W-NIB_W){1'b0}}, in_tdata[BYTE_W-1:NIB_W]};
        res.status    = ST_FUNC_LEN;
        phase_nxt     = PH_DATA;
      end
      PH_DATA: begin
        if (cnt_r < len_r) begin
          res.buf_write = 1'b1;
          res.buf_index = cnt_r + 4'd1;
          res.buf_data  = in_tdata;
          res.status    = ST_PAYLOAD;
          sum_nxt       = sum_r + in_tdata;
          cnt_nxt       = cnt_r + 4'd1;
        end else if (in_tdata == sum_r) begin
          phase_nxt  = PH_END;
          res.status = ST_SUM_OK;
        end else begin
          // bad checksum: ask for payload slots 0..len to be wiped
          res.buf_clear   = 1'b1;
          res.clear_count = {1'b0, len_r} + 5'd1;
          res.status      = ST_SUM_BAD;
          phase_nxt       = PH_START;
        end
      end
      PH_END: begin
        res.status = (in_tdata == END_BYTE) ? ST_DONE : ST_BAD_END;
        phase_nxt  = PH_START;
      end
      default: begin
        phase_nxt = PH_START;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      len_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
  end

  // output register plus skid: new beat goes to skid only when out is held
  always_comb begin
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;
    skid_nxt       = skid_r;
    skid_valid_nxt = skid_valid_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_nxt       = res;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid holds a beat while output register is empty");

  a_clear_only_on_bad_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.buf_clear |-> out_r.status == ST_SUM_BAD)
    else $error("buffer clear without checksum error");

  a_no_write_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.buf_write |-> out_r.buf_index == '0 && out_r.buf_data == '0)
    else $error("index or data set without a buffer write");

  a_start_opens_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == PH_START && in_tdata == start_r |=> phase_r == PH_DEST)
    else $error("start byte did not open a frame");
`endif

endmodule
